// File: hw/rtl/rsi_pkg.sv
package rsi_pkg;

  localparam int FRAC_BITS = 16;

  localparam int AW      = 64;
  localparam int BW      = 68;
  localparam int PRW     = 2 * BW;
  localparam int XW      = 128;
  localparam int SW      = XW / 2;
  localparam int NW      = 70;
  localparam int DW      = AW + 1;
  localparam int MW      = NW - 1 + FRAC_BITS;
  localparam int QW      = FRAC_BITS + 34;
  localparam int QTW     = QW + 1;
  localparam int MUL_LAT = 5;

  localparam logic [30:0] RAD_RESET = 31'(64'd1 << FRAC_BITS);

  typedef enum logic [1:0] {
    REG_CENTER_X   = 2'd0,
    REG_CENTER_Y   = 2'd1,
    REG_CENTER_Z   = 2'd2,
    REG_SPHERE_RAD = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0][31:0] o;
    logic [2:0][31:0] d;
  } ray_t;

  typedef struct packed {
    ray_t          ray;
    logic [AW-1:0] a;
    logic [BW-1:0] bb;
    logic          miss;
  } side_t;

  typedef struct packed {
    ray_t ray;
    logic far;
    logic miss;
  } dv_t;

  typedef struct packed {
    logic             hit;
    logic [2:0][31:0] p;
    logic             far;
    logic             ovf;
  } res_t;

endpackage

// File: hw/rtl/rsi_wide_mul.sv
module rsi_wide_mul (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [rsi_pkg::BW-1:0]   x,
  input  logic signed [rsi_pkg::BW-1:0]   y,
  output logic signed [rsi_pkg::PRW-1:0]  p
);
  import rsi_pkg::*;

  localparam int CK   = 23;
  localparam int CN   = 3;
  localparam int MAGW = CK * CN;
  localparam int RW   = 2 * CK + CK * (CN - 1) + 2;
  localparam int TW   = RW + CK * (CN - 1);

  logic [MAGW-1:0]   xe, ye, xm_nxt, ym_nxt;
  logic [MAGW-1:0]   xm_r, ym_r;
  logic [2*CK-1:0]   pp_r [CN][CN];
  logic [RW-1:0]     row_nxt [CN];
  logic [RW-1:0]     row_r [CN];
  logic [TW-1:0]     mag_nxt, mag_r;
  logic [3:0]        sg_r;
  logic signed [PRW-1:0] p_r;

  assign xe     = {{(MAGW-BW){x[BW-1]}}, x};
  assign ye     = {{(MAGW-BW){y[BW-1]}}, y};
  assign xm_nxt = x[BW-1] ? (~xe + MAGW'(1)) : xe;
  assign ym_nxt = y[BW-1] ? (~ye + MAGW'(1)) : ye;

  always_comb begin
    for (int i = 0; i < CN; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < CN; j++) begin
        row_nxt[i] = row_nxt[i] + (RW'(pp_r[i][j]) << (j * CK));
      end
    end
    mag_nxt = '0;
    for (int i = 0; i < CN; i++) begin
      mag_nxt = mag_nxt + (TW'(row_r[i]) << (i * CK));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xm_r <= xm_nxt;
      ym_r <= ym_nxt;
      sg_r <= {sg_r[2:0], x[BW-1] ^ y[BW-1]};
      for (int i = 0; i < CN; i++) begin
        for (int j = 0; j < CN; j++) begin
          pp_r[i][j] <= xm_r[i*CK +: CK] * ym_r[j*CK +: CK];
        end
      end
      row_r <= row_nxt;
      mag_r <= mag_nxt;
      p_r   <= sg_r[3] ? -PRW'(mag_r) : PRW'(mag_r);
    end
  end

  assign p = p_r;

endmodule

// File: hw/rtl/rsi_front.sv
module rsi_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_in,
  input  rsi_pkg::ray_t           ray_in,
  input  logic [2:0][31:0]        cen,
  input  logic [30:0]             rad,
  output logic                    v_out,
  output rsi_pkg::side_t          side_out,
  output logic [rsi_pkg::BW-1:0]  c_out
);
  import rsi_pkg::*;

  logic               v1_r, v2_r, v3_r;
  ray_t               ray1_r, ray2_r;
  logic signed [32:0] oc_nxt [3];
  logic signed [32:0] oc1_r [3];
  logic [30:0]        rad1_r;
  logic               miss1_r, miss2_r;
  logic signed [63:0] pdd2_r [3];
  logic signed [64:0] pod2_r [3];
  logic signed [65:0] poo2_r [3];
  logic [61:0]        prr2_r;
  logic [AW-1:0]      a_nxt;
  logic signed [BW-1:0] b_nxt, c_nxt;
  side_t              side_r;
  logic [BW-1:0]      c_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      oc_nxt[k] = $signed({ray_in.o[k][31], ray_in.o[k]}) - $signed({cen[k][31], cen[k]});
    end
    a_nxt = pdd2_r[0] + pdd2_r[1] + pdd2_r[2];
    b_nxt = pod2_r[0] + pod2_r[1] + pod2_r[2];
    c_nxt = poo2_r[0] + poo2_r[1] + poo2_r[2] - $signed({1'b0, prr2_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ray1_r  <= ray_in;
      oc1_r   <= oc_nxt;
      rad1_r  <= rad;
      miss1_r <= (ray_in.d == '0);
      ray2_r  <= ray1_r;
      miss2_r <= miss1_r;
      for (int k = 0; k < 3; k++) begin
        pdd2_r[k] <= $signed(ray1_r.d[k]) * $signed(ray1_r.d[k]);
        pod2_r[k] <= oc1_r[k] * $signed(ray1_r.d[k]);
        poo2_r[k] <= oc1_r[k] * oc1_r[k];
      end
      prr2_r       <= rad1_r * rad1_r;
      side_r.ray   <= ray2_r;
      side_r.a     <= a_nxt;
      side_r.bb    <= b_nxt;
      side_r.miss  <= miss2_r;
      c_r          <= c_nxt;
    end
  end

  assign v_out    = v3_r;
  assign side_out = side_r;
  assign c_out    = c_r;

endmodule

// File: hw/rtl/rsi_disc.sv
module rsi_disc (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_in,
  input  rsi_pkg::side_t          side_in,
  input  logic [rsi_pkg::BW-1:0]  c_in,
  output logic                    v_out,
  output logic [rsi_pkg::XW-1:0]  x_out,
  output rsi_pkg::side_t          side_out
);
  import rsi_pkg::*;

  logic signed [PRW-1:0] pbb, pac;
  logic signed [PRW:0]   diff;
  side_t                 sd_r [MUL_LAT];
  logic [MUL_LAT-1:0]    vd_r;
  logic                  v_r;
  logic [XW-1:0]         x_r;
  side_t                 side_r;

  rsi_wide_mul u_mul_bb (
    .clk (clk),
    .en  (en),
    .x   (side_in.bb),
    .y   (side_in.bb),
    .p   (pbb)
  );

  rsi_wide_mul u_mul_ac (
    .clk (clk),
    .en  (en),
    .x   ({{(BW-AW){1'b0}}, side_in.a}),
    .y   (c_in),
    .p   (pac)
  );

  // b^2 - 4ac = 4 (B^2 - a c), B = oc.d; nonnegative values stay below 2^128
  assign diff = pbb - pac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= '0;
      v_r  <= 1'b0;
    end else if (en) begin
      vd_r <= {vd_r[MUL_LAT-2:0], v_in};
      v_r  <= vd_r[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side_in;
      for (int k = 1; k < MUL_LAT; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
      x_r         <= {diff[XW-3:0], 2'b00};
      side_r.ray  <= sd_r[MUL_LAT-1].ray;
      side_r.a    <= sd_r[MUL_LAT-1].a;
      side_r.bb   <= sd_r[MUL_LAT-1].bb;
      side_r.miss <= sd_r[MUL_LAT-1].miss | diff[PRW];
    end
  end

  assign v_out    = v_r;
  assign x_out    = x_r;
  assign side_out = side_r;

endmodule

// File: hw/rtl/rsi_sqrt.sv
module rsi_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    v_in,
  input  logic [rsi_pkg::XW-1:0]  x_in,
  input  rsi_pkg::side_t          side_in,
  output logic                    v_out,
  output logic [rsi_pkg::SW-1:0]  s_out,
  output rsi_pkg::side_t          side_out
);
  import rsi_pkg::*;

  localparam int RMW = SW + 1;

  typedef struct packed {
    logic [RMW-1:0] rem;
    logic [SW-1:0]  root;
    logic [XW-1:0]  x;
    side_t          side;
  } sq_t;

  sq_t           st_r [SW];
  sq_t           st_nxt [SW];
  logic [SW-1:0] v_r;

  // one root bit per stage, restoring recurrence
  always_comb begin
    sq_t          prv;
    logic [RMW+1:0] rsh;
    logic [RMW+1:0] trial;
    logic         ge;
    for (int k = 0; k < SW; k++) begin
      if (k == 0) begin
        prv.rem  = '0;
        prv.root = '0;
        prv.x    = x_in;
        prv.side = side_in;
      end else begin
        prv = st_r[k-1];
      end
      rsh   = {prv.rem, prv.x[XW-1 -: 2]};
      trial = {1'b0, prv.root, 2'b01};
      ge    = (rsh >= trial);
      st_nxt[k].rem  = ge ? RMW'(rsh - trial) : RMW'(rsh);
      st_nxt[k].root = {prv.root[SW-2:0], ge};
      st_nxt[k].x    = prv.x << 2;
      st_nxt[k].side = prv.side;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[SW-2:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign v_out    = v_r[SW-1];
  assign s_out    = st_r[SW-1].root;
  assign side_out = st_r[SW-1].side;

endmodule

// File: hw/rtl/rsi_div.sv
module rsi_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     v_in,
  input  logic [rsi_pkg::SW-1:0]   s_in,
  input  rsi_pkg::side_t           side_in,
  output logic                     v_out,
  output logic [rsi_pkg::QTW-1:0]  t_out,
  output rsi_pkg::dv_t             dv_out
);
  import rsi_pkg::*;

  localparam int HW = MW - QW;
  localparam int VN = QW + 3;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] q;
    logic [QW-1:0] mlow;
    logic [DW-1:0] den;
    logic          clamp;
    dv_t           dv;
  } dq_t;

  logic signed [BW:0]   bb2;
  logic signed [SW:0]   se;
  logic signed [NW-1:0] n1_nxt, n2_nxt;
  logic signed [NW-1:0] n1_r, n2_r;
  logic [DW-1:0]        den0_r, den1_r;
  dv_t                  dv0_r, dv1_r;
  logic [MW-1:0]        mag1, mag2, m1_r;
  logic                 ok1, ok2;
  logic [HW-1:0]        hi;
  logic                 clamp;
  dq_t                  d2_r;
  dq_t                  st_r [QW];
  dq_t                  st_nxt [QW];
  logic [VN-1:0]        v_r;

  assign bb2    = $signed({side_in.bb, 1'b0});
  assign se     = $signed({1'b0, s_in});
  assign n1_nxt = -bb2 - se;
  assign n2_nxt = se - bb2;

  // a root is usable when it truncates to at least one
  assign mag1 = {n1_r[NW-2:0], {FRAC_BITS{1'b0}}};
  assign mag2 = {n2_r[NW-2:0], {FRAC_BITS{1'b0}}};
  assign ok1  = !n1_r[NW-1] && (mag1 >= MW'(den0_r));
  assign ok2  = !n2_r[NW-1] && (mag2 >= MW'(den0_r));

  // quotients of 2^QW and above saturate every coordinate that moves
  assign hi    = m1_r[MW-1:QW];
  assign clamp = ({{(DW-HW){1'b0}}, hi} >= den1_r);

  always_comb begin
    dq_t           prv;
    logic [DW:0]   trial;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        prv = d2_r;
      end else begin
        prv = st_r[k-1];
      end
      trial = {prv.rem, prv.mlow[QW-1]};
      ge    = (trial >= {1'b0, prv.den});
      st_nxt[k].rem   = ge ? DW'(trial - {1'b0, prv.den}) : DW'(trial);
      st_nxt[k].q     = {prv.q[QW-2:0], ge};
      st_nxt[k].mlow  = prv.mlow << 1;
      st_nxt[k].den   = prv.den;
      st_nxt[k].clamp = prv.clamp;
      st_nxt[k].dv    = prv.dv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[VN-2:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r          <= n1_nxt;
      n2_r          <= n2_nxt;
      den0_r        <= {side_in.a, 1'b0};
      dv0_r.ray     <= side_in.ray;
      dv0_r.far     <= 1'b0;
      dv0_r.miss    <= side_in.miss;

      m1_r          <= ok1 ? mag1 : mag2;
      den1_r        <= den0_r;
      dv1_r.ray     <= dv0_r.ray;
      dv1_r.far     <= !ok1;
      dv1_r.miss    <= dv0_r.miss | !(ok1 | ok2);

      d2_r.rem      <= clamp ? '0 : {{(DW-HW){1'b0}}, hi};
      d2_r.q        <= '0;
      d2_r.mlow     <= m1_r[QW-1:0];
      d2_r.den      <= den1_r;
      d2_r.clamp    <= clamp;
      d2_r.dv       <= dv1_r;

      st_r          <= st_nxt;
    end
  end

  assign v_out  = v_r[VN-1];
  assign t_out  = st_r[QW-1].clamp ? {1'b1, {QW{1'b0}}} : {1'b0, st_r[QW-1].q};
  assign dv_out = st_r[QW-1].dv;

endmodule

// File: hw/rtl/rsi_point.sv
module rsi_point (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     v_in,
  input  logic [rsi_pkg::QTW-1:0]  t_in,
  input  rsi_pkg::dv_t             dv_in,
  output logic                     v_out,
  output rsi_pkg::res_t            res_out
);
  import rsi_pkg::*;

  localparam int TL = (QTW + 1) / 2;
  localparam int TH = QTW - TL;
  localparam int PW = QTW + 33;

  logic signed [TL+32:0] plo_r [3];
  logic signed [TH+32:0] phi_r [3];
  logic signed [PW-1:0]  ph_ext [3];
  logic signed [PW-1:0]  pl_ext [3];
  logic signed [PW-1:0]  p_nxt [3];
  logic signed [PW-1:0]  p_r [3];
  logic signed [PW-1:0]  sh [3];
  logic signed [PW-1:0]  o_ext [3];
  logic signed [PW-1:0]  vv [3];
  logic [PW-32:0]        top [3];
  logic [2:0]            inr;
  dv_t                   dv1_r, dv2_r;
  res_t                  res_nxt, res_r;
  logic [2:0]            v_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ph_ext[k] = phi_r[k];
      pl_ext[k] = plo_r[k];
      p_nxt[k]  = (ph_ext[k] <<< TL) + pl_ext[k];
      sh[k]     = p_r[k] >>> FRAC_BITS;
      o_ext[k]  = $signed(dv2_r.ray.o[k]);
      vv[k]     = sh[k] + o_ext[k];
      top[k]    = vv[k][PW-1:31];
      inr[k]    = (&top[k]) | ~(|top[k]);
    end
    res_nxt.hit = !dv2_r.miss;
    res_nxt.far = !dv2_r.miss && dv2_r.far;
    res_nxt.ovf = !dv2_r.miss && !(&inr);
    for (int k = 0; k < 3; k++) begin
      if (dv2_r.miss) begin
        res_nxt.p[k] = '0;
      end else if (inr[k]) begin
        res_nxt.p[k] = vv[k][31:0];
      end else begin
        res_nxt.p[k] = vv[k][PW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], v_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        plo_r[k] <= $signed({1'b0, t_in[TL-1:0]}) * $signed(dv_in.ray.d[k]);
        phi_r[k] <= $signed({1'b0, t_in[QTW-1:TL]}) * $signed(dv_in.ray.d[k]);
      end
      dv1_r <= dv_in;
      p_r   <= p_nxt;
      dv2_r <= dv1_r;
      res_r <= res_nxt;
    end
  end

  assign v_out   = v_r[2];
  assign res_out = res_r;

endmodule

// File: hw/rtl/ray_sphere_intersection_unit.sv
// Ray / sphere intersection, fixed point Q16.16, one ray per cycle while in_ready is high.
// Input channel in_*: one beat is a ray (origin, direction). Output channel
// out_*: one beat per ray, in order: hit, intersection point, far_root
// (ray starts inside the sphere) and overflow (a coordinate saturated).
// Misses (zero direction, negative discriminant, no positive root) give hit 0
// and zeros in every other field.
// Config channel cfg_*: index 0..2 center x/y/z, 3 radius (low 31 data bits).
// cfg_ready is always high; write only while no ray is in flight.
// The 64 square root stages and the FRAC_BITS + 34 divider stages make up most of the pipeline.
// Throughput is one ray per cycle while in_ready is high; every stage advances together.
// When the receiver stalls, the output register holds its beat and a skid
// register catches the next one; in_ready then drops until the skid drains.
// Synchronous reset clears all valid bits, the center to 0 and the radius
// to 1.0.
module ray_sphere_intersection_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_origin_x,
  input  logic [31:0] in_origin_y,
  input  logic [31:0] in_origin_z,
  input  logic [31:0] in_dir_x,
  input  logic [31:0] in_dir_y,
  input  logic [31:0] in_dir_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [31:0] out_point_x,
  output logic [31:0] out_point_y,
  output logic [31:0] out_point_z,
  output logic        out_far_root,
  output logic        out_overflow,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rsi_pkg::*;

  logic [2:0][31:0] cen_r;
  logic [30:0]      rad_r;
  logic             en;
  ray_t             ray_in;

  logic             fr_v;
  side_t            fr_side;
  logic [BW-1:0]    fr_c;
  logic             dc_v;
  logic [XW-1:0]    dc_x;
  side_t            dc_side;
  logic             sq_v;
  logic [SW-1:0]    sq_s;
  side_t            sq_side;
  logic             dv_v;
  logic [QTW-1:0]   dv_t_val;
  dv_t              dv_side;
  logic             pt_v;
  res_t             pt_res;

  logic             out_v_r, skid_v_r;
  res_t             out_res_r, skid_res_r;
  logic             arrive;

  assign cfg_ready = 1'b1;
  assign en        = !skid_v_r;
  assign in_ready  = en;
  assign ray_in.o  = {in_origin_z, in_origin_y, in_origin_x};
  assign ray_in.d  = {in_dir_z, in_dir_y, in_dir_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r <= '0;
      rad_r <= RAD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CENTER_X:   cen_r[0] <= cfg_data;
        REG_CENTER_Y:   cen_r[1] <= cfg_data;
        REG_CENTER_Z:   cen_r[2] <= cfg_data;
        REG_SPHERE_RAD: rad_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  rsi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (in_valid),
    .ray_in   (ray_in),
    .cen      (cen_r),
    .rad      (rad_r),
    .v_out    (fr_v),
    .side_out (fr_side),
    .c_out    (fr_c)
  );

  rsi_disc u_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (fr_v),
    .side_in  (fr_side),
    .c_in     (fr_c),
    .v_out    (dc_v),
    .x_out    (dc_x),
    .side_out (dc_side)
  );

  rsi_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_in     (dc_v),
    .x_in     (dc_x),
    .side_in  (dc_side),
    .v_out    (sq_v),
    .s_out    (sq_s),
    .side_out (sq_side)
  );

  rsi_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (sq_v),
    .s_in    (sq_s),
    .side_in (sq_side),
    .v_out   (dv_v),
    .t_out   (dv_t_val),
    .dv_out  (dv_side)
  );

  rsi_point u_point (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (dv_v),
    .t_in    (dv_t_val),
    .dv_in   (dv_side),
    .v_out   (pt_v),
    .res_out (pt_res)
  );

  assign arrive = en && pt_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (arrive) begin
      if (out_v_r && !out_ready) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_res_r <= skid_res_r;
      end
    end else if (arrive) begin
      if (out_v_r && !out_ready) begin
        skid_res_r <= pt_res;
      end else begin
        out_res_r <= pt_res;
      end
    end
  end

  assign out_valid    = out_v_r;
  assign out_hit      = out_res_r.hit;
  assign out_point_x  = out_res_r.p[0];
  assign out_point_y  = out_res_r.p[1];
  assign out_point_z  = out_res_r.p[2];
  assign out_far_root = out_res_r.far;
  assign out_overflow = out_res_r.ovf;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a beat while the output register is empty");

  a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready && !skid_v_r && pt_v) |=> skid_v_r)
    else $error("beat arriving at a stalled output was not caught");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_point_x == 32'd0 && out_point_y == 32'd0 &&
      out_point_z == 32'd0 && !out_far_root && !out_overflow))
    else $error("miss beat carries nonzero fields");

  a_flags_need_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_far_root || out_overflow)) |-> out_hit)
    else $error("far_root or overflow set without hit");

endmodule

// File: tb/sv/rsi_checker.sv
`timescale 1ns / 1ps

module rsi_checker
  import rsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_origin_x,
  input  logic [31:0] in_origin_y,
  input  logic [31:0] in_origin_z,
  input  logic [31:0] in_dir_x,
  input  logic [31:0] in_dir_y,
  input  logic [31:0] in_dir_z,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_hit,
  input  logic [31:0] out_point_x,
  input  logic [31:0] out_point_y,
  input  logic [31:0] out_point_z,
  input  logic        out_far_root,
  input  logic        out_overflow,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  typedef logic signed [255:0] wint_t;

  logic [2:0][31:0] center;
  logic [30:0]      radius;
  res_t             hits_q[$];

  function automatic logic [31:0] clamp32(wint_t v, inout logic ovf);
    if (v > wint_t'(32'sh7fffffff)) begin
      ovf = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -wint_t'(64'sh80000000)) begin
      ovf = 1'b1;
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  function automatic res_t trace_ray(logic [2:0][31:0] org, logic [2:0][31:0] dir);
    wint_t       a, b, c, oc, dk, disc, den, t1, t2, t, p;
    logic [255:0] s, cand, disc_u;
    res_t        r;
    r = '0;
    a = 0;
    b = 0;
    c = 0;
    for (int k = 0; k < 3; k++) begin
      dk = $signed(dir[k]);
      oc = wint_t'($signed(org[k])) - wint_t'($signed(center[k]));
      a = a + dk * dk;
      b = b + oc * dk;
      c = c + oc * oc;
    end
    b = b * 2;
    c = c - wint_t'({1'b0, radius}) * wint_t'({1'b0, radius});
    if (a == 0) return r;
    disc = b * b - 4 * a * c;
    if (disc < 0) return r;
    disc_u = disc;
    s = '0;
    for (int i = 127; i >= 0; i--) begin
      cand = s | (256'd1 << i);
      if (cand * cand <= disc_u) s = cand;
    end
    den = 2 * a;
    t1 = ((-b - wint_t'(s)) * 65536) / den;
    t2 = ((wint_t'(s) - b) * 65536) / den;
    if (t1 > 0) t = t1;
    else if (t2 > 0) begin
      t = t2;
      r.far = 1'b1;
    end else return r;
    r.hit = 1'b1;
    for (int k = 0; k < 3; k++) begin
      p = ((t * wint_t'($signed(dir[k]))) >>> FRAC_BITS) + wint_t'($signed(org[k]));
      r.p[k] = clamp32(p, r.ovf);
    end
    return r;
  endfunction

  assign pending = hits_q.size();

  always @(posedge clk) begin
    res_t want, got;
    if (!rst_n) begin
      center <= '0;
      radius <= RAD_RESET;
      errors <= 0;
      hits_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CENTER_X:   center[0] <= cfg_data;
          REG_CENTER_Y:   center[1] <= cfg_data;
          REG_CENTER_Z:   center[2] <= cfg_data;
          REG_SPHERE_RAD: radius    <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got.hit = out_hit;
        got.p   = {out_point_z, out_point_y, out_point_x};
        got.far = out_far_root;
        got.ovf = out_overflow;
        if (hits_q.size() == 0) begin
          if (errors < 10) $display("unexpected out beat: %p", got);
          errors <= errors + 1;
        end else begin
          want = hits_q.pop_front();
          if (got !== want) begin
            if (errors < 10)
              $display("mismatch: exp hit=%0b p=%h/%h/%h far=%0b ovf=%0b act hit=%0b p=%h/%h/%h far=%0b ovf=%0b",
                       want.hit, want.p[0], want.p[1], want.p[2], want.far, want.ovf,
                       got.hit, got.p[0], got.p[1], got.p[2], got.far, got.ovf);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready)
        hits_q.push_back(trace_ray({in_origin_z, in_origin_y, in_origin_x},
                                   {in_dir_z, in_dir_y, in_dir_x}));
    end
  end

endmodule

// File: tb/sv/tb_ray_sphere_intersection_unit.sv
`timescale 1ns / 1ps

module tb_ray_sphere_intersection_unit;
  import rsi_pkg::*;

  localparam int LAT = 140;
  localparam int ONE = 65536;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_hit;
  logic [31:0] out_point_x, out_point_y, out_point_z;
  logic        out_far_root, out_overflow;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          errors, pending;
  bit          quiet = 1'b0;
  int          stall_left = 0;
  logic [2:0][31:0] cur_center;
  int          cur_rad;

  ray_sphere_intersection_unit u_top (.*);
  rsi_checker u_chk (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL ray_sphere_intersection_unit");
    $finish;
  end

  always @(posedge clk) begin
    if (quiet || !rst_n) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else out_ready <= 1'b1;
  end

  task automatic cfg_write(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [30:0] rad);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(REG_CENTER_Z, cz);
    cfg_write(REG_SPHERE_RAD, {1'b0, rad});
    cfg_valid <= 1'b0;
    cur_center = {cz, cy, cx};
    cur_rad = rad;
  endtask

  task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_origin_x <= ox;
    in_origin_y <= oy;
    in_origin_z <= oz;
    in_dir_x    <= dx;
    in_dir_y    <= dy;
    in_dir_z    <= dz;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic random_ray();
    logic [2:0][31:0] o, d;
    longint           span, off;
    int               kind;
    kind = $urandom_range(0, 9);
    span = longint'(cur_rad) * 3 + ONE;
    if (span > 64'h7fffffff) span = 64'h7fffffff;
    for (int k = 0; k < 3; k++) begin
      case (kind)
        0, 1: begin
          o[k] = $urandom;
          d[k] = $urandom;
        end
        2: begin
          o[k] = $urandom_range(0, 2 * ONE) - ONE;
          d[k] = $urandom_range(0, 511) - 256;
        end
        3, 4: begin
          off  = longint'($urandom_range(0, 2000)) - 1000;
          o[k] = 32'(longint'($signed(cur_center[k])) + off * span / 4000);
          d[k] = $urandom_range(0, 2 * ONE) - ONE;
        end
        default: begin
          off  = (longint'($urandom) % (2 * span)) - span;
          o[k] = 32'(longint'($signed(cur_center[k])) + off);
          off  = longint'($signed(cur_center[k])) - longint'($signed(o[k]))
                 + (longint'($urandom_range(0, 2000)) - 1000) * span / 4000;
          d[k] = 32'(off >>> $urandom_range(0, 12));
        end
      endcase
    end
    send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
  endtask

  initial begin
    logic [30:0] rnd_rad;
    cur_center = '0;
    cur_rad = ONE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default unit sphere at origin
    send_ray(-5 * ONE, 0, 0, ONE, 0, 0);
    send_ray(0, 0, 0, 0, 0, ONE);
    send_ray(0, 0, 0, 0, 0, 0);
    send_ray(-5 * ONE, 2 * ONE, 0, ONE, 0, 0);
    send_ray(5 * ONE, 0, 0, ONE, 0, 0);
    send_ray(-5 * ONE, ONE, 0, ONE, 0, 0);
    send_ray(-5 * ONE, 0, 0, 1, 0, 0);
    send_ray(-ONE, 0, 0, 32'h7fffffff, 0, 0);
    send_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
             32'h7fffffff);
    send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
             32'h80000000);
    send_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0);
    send_ray(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
    send_ray(ONE / 2, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_ray(ONE, 0, 0, ONE, 0, 0);
    send_ray(0, 0, -3 * ONE, 0, 0, 2 * ONE);

    set_sphere(32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff);
    send_ray(32'h80000000, 32'h80000000, 32'h80000000, ONE, ONE, ONE);
    send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0);
    send_ray(32'h7fffffff, 0, 0, 32'h7fffffff, 0, 0);
    send_ray(0, 0, 0, 1, 1, 1);

    set_sphere(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'd0);
    send_ray(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, ONE, 0, 0);
    send_ray(32'h7ffffffe, 32'h7fffffff, 32'h7fffffff, 1, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      rnd_rad = (ph == 0) ? 31'd0 : (ph == 5) ? 31'h7fffffff : 31'($urandom_range(1, 200 * ONE));
      set_sphere($urandom, $urandom, $urandom, rnd_rad);
      if (ph == 1) set_sphere($urandom_range(0, 20 * ONE) - 10 * ONE,
                              $urandom_range(0, 20 * ONE) - 10 * ONE,
                              $urandom_range(0, 20 * ONE) - 10 * ONE, rnd_rad);
      for (int n = 0; n < 180; n++) begin
        if (ph == 5 && n == 30) quiet = 1'b1;
        random_ray();
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
    if (errors == 0 && pending == 0) $display("PASS ray_sphere_intersection_unit");
    else $display("FAIL ray_sphere_intersection_unit");
    $finish;
  end

endmodule
